/* sv/sha1_pkg.sv */
// ----------------------------------------------------------------------------
// SHA-1 engine package
// Shared types, constants and round functions for the SHA-1 hash engine.
// ----------------------------------------------------------------------------
package sha1_pkg;

    localparam int NUM_WORDS   = 5;
    localparam int SCHED_WORDS = 16;
    localparam int NUM_ROUNDS  = 80;
    localparam int ROUND_W     = 7;

    typedef logic [31:0] t_word;

    // Initial chaining value of the standard.
    localparam t_word H_INIT [NUM_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    // Padding marker byte and block positions used while padding.
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] LAST_POS = 6'd63;

    // Index of the final digest word.
    localparam logic [2:0] LAST_IDX = 3'd4;

    // Round group selects one of the four round functions and constants.
    typedef enum logic [1:0] {
        F_CHOOSE,
        F_PARITY_LO,
        F_MAJORITY,
        F_PARITY_HI
    } t_fsel;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD_INIT,
        ST_PAD,
        ST_ROUND,
        ST_UPDATE,
        ST_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  push_byte;
        logic  push_pad;
        logic  pad_init;
        logic  round_load;
        logic  round_step;
        logic  update;
        logic  set_last_blk;
        logic  finish;
        t_fsel fsel;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic block_full;
        logic last_blk;
        logic out_busy;
    } t_dp_sts;

    function automatic t_word round_const(input t_fsel sel);
        t_word k;
        unique case (sel)
            F_CHOOSE:    k = 32'h5A827999;
            F_PARITY_LO: k = 32'h6ED9EBA1;
            F_MAJORITY:  k = 32'h8F1BBCDC;
            F_PARITY_HI: k = 32'hCA62C1D6;
            default:     k = 32'h5A827999;
        endcase
        return k;
    endfunction

    function automatic t_word round_func(input t_fsel sel, input t_word b,
                                         input t_word c, input t_word d);
        t_word f;
        unique case (sel)
            F_CHOOSE:   f = (b & c) | (~b & d);
            F_MAJORITY: f = (b & c) | (b & d) | (c & d);
            default:    f = b ^ c ^ d;
        endcase
        return f;
    endfunction

endpackage

/* sv/sha1_ctrl.sv */
// ----------------------------------------------------------------------------
// SHA-1 engine controller
// Sequences byte intake, padding, the 80 compression rounds and the
// hand-off of the finished digest to the output register.
// ----------------------------------------------------------------------------
module sha1_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_byte_valid,
    input  logic              i_end_of_message,
    output logic              o_stall,
    input  sha1_pkg::t_dp_sts i_sts,
    output sha1_pkg::t_dp_cmd o_cmd
);
    import sha1_pkg::*;

    t_state             r_state, n_state;
    logic [ROUND_W-1:0] r_round, n_round;
    logic               r_eom, n_eom;
    logic               r_padding, n_padding;
    logic               w_fire;

    // Input transfers are taken only while waiting for bytes.
    assign o_stall = (r_state != ST_IDLE);
    assign w_fire  = i_valid && !o_stall;

    // State and sequencing registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_round   <= '0;
            r_eom     <= 1'b0;
            r_padding <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_round   <= n_round;
            r_eom     <= n_eom;
            r_padding <= n_padding;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state   = r_state;
        n_round   = r_round;
        n_eom     = r_eom;
        n_padding = r_padding;
        o_cmd     = '0;

        // Round group from the round counter.
        priority if (r_round < ROUND_W'(20)) begin
            o_cmd.fsel = F_CHOOSE;
        end else if (r_round < ROUND_W'(40)) begin
            o_cmd.fsel = F_PARITY_LO;
        end else if (r_round < ROUND_W'(60)) begin
            o_cmd.fsel = F_MAJORITY;
        end else begin
            o_cmd.fsel = F_PARITY_HI;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_fire) begin
                    n_eom = i_end_of_message;
                    if (i_byte_valid) begin
                        o_cmd.push_byte = 1'b1;
                        if (i_sts.block_full) begin
                            o_cmd.round_load = 1'b1;
                            n_round          = '0;
                            n_state          = ST_ROUND;
                        end else if (i_end_of_message) begin
                            n_state = ST_PAD_INIT;
                        end
                    end else if (i_end_of_message) begin
                        n_state = ST_PAD_INIT;
                    end
                end
            end
            ST_PAD_INIT: begin
                o_cmd.pad_init = 1'b1;
                n_padding      = 1'b1;
                n_state        = ST_PAD;
            end
            ST_PAD: begin
                o_cmd.push_pad = 1'b1;
                if (i_sts.block_full) begin
                    o_cmd.round_load = 1'b1;
                    n_round          = '0;
                    n_state          = ST_ROUND;
                end
            end
            ST_ROUND: begin
                o_cmd.round_step = 1'b1;
                if (r_round == ROUND_W'(NUM_ROUNDS - 1)) begin
                    n_state = ST_UPDATE;
                end else begin
                    n_round = r_round + 1'b1;
                end
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
                if (r_padding) begin
                    if (i_sts.last_blk) begin
                        n_state = ST_FINISH;
                    end else begin
                        o_cmd.set_last_blk = 1'b1;
                        n_state            = ST_PAD;
                    end
                end else if (r_eom) begin
                    n_state = ST_PAD_INIT;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_FINISH: begin
                // Wait until the previous digest has been fully taken.
                if (!i_sts.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_padding    = 1'b0;
                    n_eom        = 1'b0;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

/* sv/sha1_dpath.sv */
// ----------------------------------------------------------------------------
// SHA-1 engine datapath
// Message schedule window, working variables, chaining value, byte count,
// padding generator and the digest output register.
// ----------------------------------------------------------------------------
module sha1_dpath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sha1_pkg::t_dp_cmd i_cmd,
    output sha1_pkg::t_dp_sts o_sts,
    input  logic [7:0]        i_data_byte,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [31:0]       o_digest_word,
    output logic [2:0]        o_word_index,
    output logic              o_last_word
);
    import sha1_pkg::*;

    t_word       r_win [SCHED_WORDS];
    t_word       r_wk  [NUM_WORDS];
    t_word       r_h   [NUM_WORDS];
    t_word       r_dig [NUM_WORDS];
    logic [60:0] r_cnt;
    logic [5:0]  r_pos;
    logic        r_first;
    logic        r_last_blk;
    logic [63:0] r_bits;
    logic [2:0]  r_oidx;
    logic        r_ovalid;

    logic        w_push;
    logic        w_len_zone;
    logic [7:0]  w_byte;
    t_word       w_sum;
    t_word       w_sched;
    t_word       w_mix;
    logic        w_out_xfer;

    // Byte entering the window: message byte or padding byte.
    assign w_push     = i_cmd.push_byte || i_cmd.push_pad;
    assign w_len_zone = r_last_blk && (r_pos >= LEN_POS) && !r_first;

    always_comb begin
        if (i_cmd.push_byte) begin
            w_byte = i_data_byte;
        end else if (r_first) begin
            w_byte = PAD_BYTE;
        end else if (w_len_zone) begin
            w_byte = r_bits[63:56];
        end else begin
            w_byte = 8'h00;
        end
    end

    // One SHA-1 round and the next schedule word.
    assign w_sum = {r_wk[0][26:0], r_wk[0][31:27]}
                 + round_func(i_cmd.fsel, r_wk[1], r_wk[2], r_wk[3])
                 + r_wk[4] + round_const(i_cmd.fsel) + r_win[0];
    assign w_mix   = r_win[13] ^ r_win[8] ^ r_win[2] ^ r_win[0];
    assign w_sched = {w_mix[30:0], w_mix[31]};

    // Schedule window: byte-wise shift while filling, word-wise in rounds.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            for (int j = 0; j < SCHED_WORDS - 1; j++) begin
                r_win[j] <= {r_win[j][23:0], r_win[j+1][31:24]};
            end
            r_win[SCHED_WORDS-1] <= {r_win[SCHED_WORDS-1][23:0], w_byte};
        end else if (i_cmd.round_step) begin
            for (int j = 0; j < SCHED_WORDS - 1; j++) begin
                r_win[j] <= r_win[j+1];
            end
            r_win[SCHED_WORDS-1] <= w_sched;
        end
    end

    // Working variables a through e.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_WORDS; i++) begin
                r_wk[i] <= '0;
            end
        end else if (i_cmd.round_load) begin
            r_wk <= r_h;
        end else if (i_cmd.round_step) begin
            r_wk[0] <= w_sum;
            r_wk[1] <= r_wk[0];
            r_wk[2] <= {r_wk[1][1:0], r_wk[1][31:2]};
            r_wk[3] <= r_wk[2];
            r_wk[4] <= r_wk[3];
        end
    end

    // Chaining value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h <= H_INIT;
        end else if (i_cmd.update) begin
            for (int i = 0; i < NUM_WORDS; i++) begin
                r_h[i] <= r_h[i] + r_wk[i];
            end
        end else if (i_cmd.finish) begin
            r_h <= H_INIT;
        end
    end

    // Byte count, block position and padding state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_pos      <= '0;
            r_first    <= 1'b0;
            r_last_blk <= 1'b0;
        end else begin
            if (i_cmd.push_byte) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_cmd.finish) begin
                r_cnt <= '0;
            end
            if (w_push) begin
                r_pos <= r_pos + 1'b1;
            end else if (i_cmd.finish) begin
                r_pos <= '0;
            end
            if (i_cmd.pad_init) begin
                r_first    <= 1'b1;
                r_last_blk <= (r_pos < LEN_POS);
            end else begin
                if (i_cmd.push_pad) begin
                    r_first <= 1'b0;
                end
                if (i_cmd.set_last_blk) begin
                    r_last_blk <= 1'b1;
                end
            end
        end
    end

    // Message length in bits, shifted out most significant byte first.
    always_ff @(posedge i_clk) begin
        if (i_cmd.pad_init) begin
            r_bits <= {r_cnt, 3'b000};
        end else if (i_cmd.push_pad && w_len_zone) begin
            r_bits <= {r_bits[55:0], 8'h00};
        end
    end

    // Digest output register, shifted out one word per transfer.
    assign w_out_xfer = r_ovalid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_dig <= r_h;
        end else if (w_out_xfer) begin
            for (int i = 0; i < NUM_WORDS - 1; i++) begin
                r_dig[i] <= r_dig[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_oidx   <= '0;
        end else if (i_cmd.finish) begin
            r_ovalid <= 1'b1;
            r_oidx   <= '0;
        end else if (w_out_xfer) begin
            if (r_oidx == LAST_IDX) begin
                r_ovalid <= 1'b0;
            end
            r_oidx <= r_oidx + 1'b1;
        end
    end

    assign o_valid       = r_ovalid;
    assign o_digest_word = r_dig[0];
    assign o_word_index  = r_oidx;
    assign o_last_word   = (r_oidx == LAST_IDX);

    assign o_sts.block_full = (r_pos == LAST_POS);
    assign o_sts.last_blk   = r_last_blk;
    assign o_sts.out_busy   = r_ovalid;

endmodule

/* sv/sha1_hash_engine.sv */
// ----------------------------------------------------------------------------
// SHA-1 hash engine
// Streaming SHA-1 with 160-bit digest, one message byte per input transfer.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle while the engine waits for input; each
// 64th byte starts the compression, which runs its rounds at one round
// per cycle and then folds the result into the chaining value, while
// o_stall is high. End of message passes through a setup state, pads up
// to the block end and compresses each padded block (one or two blocks),
// then loads the output register, after which the five digest words
// leave most significant first. The next message may stream in while
// that digest is still being taken; a following digest waits for it.
module sha1_hash_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_valid,
    input  logic        i_end_of_message,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    import sha1_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // Sequencer.
    sha1_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .i_byte_valid     (i_byte_valid),
        .i_end_of_message (i_end_of_message),
        .o_stall          (o_stall),
        .i_sts            (w_sts),
        .o_cmd            (w_cmd)
    );

    // Hash datapath and output register.
    sha1_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_data_byte   (i_data_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

    // A new digest is never loaded over one that is still being sent.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.finish && w_sts.out_busy))
        else $error("digest loaded while output busy");

    // The output goes idle after the transfer of the final word.
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_last_word) |=> !o_valid)
        else $error("output still valid after final word");

    // No input is taken while the rounds run.
    a_stall_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.round_step |-> o_stall)
        else $error("input accepted during compression");

    // The final-word flag marks exactly the fifth word.
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_word == (o_word_index == LAST_IDX)))
        else $error("final-word flag and word index disagree");

endmodule
